/* sv/tds_pkg.sv */
// Package with shared types and constants for the timer divisor search block.
`timescale 1ns / 1ps

package tds_pkg;

    // Upper bound, exclusive, on both the prescale divisor and the quotient.
    localparam int unsigned COUNT_LIMIT = 65535;
    // Width of the divisor candidate: it can climb to COUNT_LIMIT + 3.
    localparam int unsigned CAND_W = $clog2(COUNT_LIMIT + 1) + 1;
    localparam logic [31:0] LIMIT_32 = 32'(COUNT_LIMIT);
    localparam logic [31:0] MS_PER_S = 32'd1000;

    // One input item.
    typedef struct packed {
        logic [31:0] clock_hz;
        logic [31:0] clock_multiplier;
        logic [31:0] period_ms;
    } t_in;

    // One result item.
    typedef struct packed {
        logic        status;
        logic [15:0] divider;
        logic [15:0] reload;
    } t_out;

    // Result status codes.
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    // Request to the shared divider.
    typedef struct packed {
        logic        go;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    // Answer from the shared divider.
    typedef struct packed {
        logic        done;
        logic [31:0] quot;
        logic [31:0] rem;
    } t_div_rsp;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_CLK,
        S_DIVK_GO,
        S_DIVK_WAIT,
        S_MUL_IVL,
        S_ZERO_CHK,
        S_DIVL_WAIT,
        S_TRY_GO,
        S_TRY_WAIT,
        S_EMIT
    } t_state;

endpackage

/* sv/timer_divisor_search.sv */
// Top level of the timer divisor search: sequencer, shared multiplier and divider.
`timescale 1ns / 1ps

// Usage:
//   Drive i_item and raise start; the item is taken at a clock edge where start
//   is high and busy is low. busy stays high until the result has been shown.
//   The result appears on o_result for exactly one cycle with o_done high; the
//   receiver cannot hold it off and must take it in that cycle.
// Operation:
//   One 32-bit multiplier forms the wrapped product clock * multiplier and
//   later product / 1000 * interval. One restoring divider (32 steps, one bit
//   a cycle) gives the division by 1000, the start divisor target / limit + 1,
//   and then one division per divisor candidate.
// Sequence:
//   A zero target goes straight to the result; otherwise divisor candidates
//   are tried in turn until one fits or reaches the limit. One item is worked
//   on at a time.
// Reset:
//   Synchronous, active low; the block returns to idle and drops o_done.
//   Nothing else is held between items.

module timer_divisor_search (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  tds_pkg::t_in  i_item,
    output logic          busy,
    output logic          o_done,
    output tds_pkg::t_out o_result
);
    import tds_pkg::*;

    t_state r_state, n_state;

    t_in               r_in,     n_in;
    logic [31:0]       r_target, n_target;
    logic [CAND_W-1:0] r_cand,   n_cand;
    t_out              r_out,    n_out;
    logic              r_done,   n_done;

    t_div_req w_req;
    t_div_rsp w_rsp;

    logic [31:0] w_mul_a;
    logic [31:0] w_mul_b;
    logic [31:0] w_prod;
    logic        w_hit;

    // Shared divider.
    tds_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    // Shared multiplier; the low word gives the wrapped product.
    assign w_mul_a = (r_state == S_MUL_CLK) ? r_in.clock_hz : r_target;
    assign w_mul_b = (r_state == S_MUL_CLK) ? r_in.clock_multiplier : r_in.period_ms;
    assign w_prod  = w_mul_a * w_mul_b;

    // A candidate fits when it divides exactly with a quotient under the limit.
    assign w_hit = (w_rsp.quot < LIMIT_32) && (w_rsp.rem == '0);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start && !busy) n_state = S_MUL_CLK;
            end
            S_MUL_CLK:   n_state = S_DIVK_GO;
            S_DIVK_GO:   n_state = S_DIVK_WAIT;
            S_DIVK_WAIT: begin
                if (w_rsp.done) n_state = S_MUL_IVL;
            end
            S_MUL_IVL:   n_state = S_ZERO_CHK;
            S_ZERO_CHK: begin
                n_state = (r_target == '0) ? S_EMIT : S_DIVL_WAIT;
            end
            S_DIVL_WAIT: begin
                if (w_rsp.done) n_state = S_TRY_GO;
            end
            S_TRY_GO: begin
                n_state = (r_cand >= CAND_W'(COUNT_LIMIT)) ? S_EMIT : S_TRY_WAIT;
            end
            S_TRY_WAIT: begin
                if (w_rsp.done) n_state = w_hit ? S_EMIT : S_TRY_GO;
            end
            S_EMIT:      n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // Datapath updates and divider requests.
    always_comb begin
        n_in           = r_in;
        n_target       = r_target;
        n_cand         = r_cand;
        n_out          = r_out;
        n_done         = 1'b0;
        w_req.go       = 1'b0;
        w_req.dividend = r_target;
        w_req.divisor  = MS_PER_S;
        case (r_state)
            S_IDLE: begin
                if (start && !busy) n_in = i_item;
                n_out = '{status: STATUS_FAIL, divider: 16'd0, reload: 16'd0};
            end
            S_MUL_CLK: n_target = w_prod;
            S_DIVK_GO: w_req.go = 1'b1;
            S_DIVK_WAIT: begin
                if (w_rsp.done) n_target = w_rsp.quot;
            end
            S_MUL_IVL: n_target = w_prod;
            S_ZERO_CHK: begin
                w_req.go      = (r_target != '0);
                w_req.divisor = LIMIT_32;
            end
            S_DIVL_WAIT: begin
                if (w_rsp.done) n_cand = CAND_W'(w_rsp.quot) + CAND_W'(1);
            end
            S_TRY_GO: begin
                w_req.go      = (r_cand < CAND_W'(COUNT_LIMIT));
                w_req.divisor = 32'(r_cand);
            end
            S_TRY_WAIT: begin
                if (w_rsp.done) begin
                    if (w_hit) begin
                        // A quotient of one would give a zero reload: failure.
                        if (w_rsp.quot > 32'd1) begin
                            n_out.status  = STATUS_OK;
                            n_out.divider = r_cand[15:0];
                            n_out.reload  = w_rsp.quot[15:0] - 16'd1;
                        end
                    end else begin
                        n_cand = r_cand + CAND_W'(1);
                    end
                end
            end
            S_EMIT: n_done = 1'b1;
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_in     <= n_in;
        r_target <= n_target;
        r_cand   <= n_cand;
        r_out    <= n_out;
    end

    assign busy     = (r_state != S_IDLE) || r_done;
    assign o_done   = r_done;
    assign o_result = r_out;

endmodule

/* sv/tds_div.sv */
// Shared restoring divider, 32 by 32 bits, one quotient bit per cycle.
`timescale 1ns / 1ps

module tds_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tds_pkg::t_div_req i_req,
    output tds_pkg::t_div_rsp o_rsp
);
    import tds_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_den;

    logic [32:0] w_shift;
    logic [32:0] w_diff;

    // Trial subtraction for the current bit.
    assign w_shift = {r_rem, r_quo[31]};
    assign w_diff  = w_shift - {1'b0, r_den};

    // Control: a go starts 32 steps, done pulses once after the last one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and quotient shift left together.
    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            if (!w_diff[32]) begin
                r_rem <= w_diff[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= w_shift[31:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule
